[src/bti_pkg.sv]
// Shared types and codes for the beam top-k insert/recombine unit.
// No dependencies; used by every module in src/.
package bti_pkg;

    localparam int BEAM_MAX_DEF = 16;

    localparam logic [4:0] BEAM_WIDTH_RST = 5'd16;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_CLEARED   = 3'd0;
    localparam logic [2:0] STAT_INSERTED  = 3'd1;
    localparam logic [2:0] STAT_REPLACED  = 3'd2;
    localparam logic [2:0] STAT_REJ_FULL  = 3'd3;
    localparam logic [2:0] STAT_REJ_DOM   = 3'd4;
    localparam logic [2:0] STAT_READ_OK   = 3'd5;
    localparam logic [2:0] STAT_READ_EMPTY = 3'd6;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         tag_prev;
        logic [7:0]         tag_cur;
        logic signed [31:0] cand_score;
        logic [3:0]         back_index;
        logic [3:0]         read_slot;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         entry_count;
        logic [3:0]         position;
        logic [7:0]         out_tag_prev;
        logic [7:0]         out_tag_cur;
        logic signed [31:0] out_score;
        logic [3:0]         out_back_index;
    } out_beat_t;

    // one hypothesis as held by a cell
    typedef struct packed {
        logic [7:0]         tag_prev;
        logic [7:0]         tag_cur;
        logic signed [31:0] score;
        logic [3:0]         back;
    } hyp_t;

    // broadcast to every cell
    typedef struct packed {
        logic eval;    // latch compare flags against the candidate
        logic commit;  // apply insert / shift
        logic found;   // an equivalent entry is being replaced
    } cell_ctrl_t;

    // summary of the cell flags
    typedef struct packed {
        logic found;        // valid entry with same key
        logic full_reject;  // beam full and candidate does not beat the tail
        logic dominated;    // equivalent entry scores at least as high
    } scan_flags_t;

endpackage

[src/bti_cell.sv]
// One beam slot: holds a hypothesis, compares it with the broadcast candidate
// and takes the candidate or its upper neighbor on commit. Uses bti_pkg.
module bti_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  bti_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]  pos,
    input  logic [IDX_W-1:0]  k_idx,
    input  bti_pkg::hyp_t     cand,
    input  bti_pkg::hyp_t     prev,
    output bti_pkg::hyp_t     entry,
    output logic              gt,
    output logic              match
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    bti_pkg::hyp_t entry_reg;
    logic          gt_reg;
    logic          match_reg;
    logic          take_cand;
    logic          take_prev;

    assign take_cand = ctrl.commit && (MY_IDX == pos);
    assign take_prev = ctrl.commit && (MY_IDX > pos) && (!ctrl.found || MY_IDX <= k_idx);

    always_ff @(posedge clk)
    begin
        if (ctrl.eval)
        begin
            gt_reg    <= $signed(cand.score) > $signed(entry_reg.score);
            match_reg <= (cand.tag_prev == entry_reg.tag_prev) &&
                         (cand.tag_cur == entry_reg.tag_cur);
        end
        if (take_cand)
        begin
            entry_reg <= cand;
        end
        else if (take_prev)
        begin
            entry_reg <= prev;
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign match = match_reg;

endmodule

[src/bti_scan.sv]
// Reduces the per-slot flags to the insert decision: landing slot,
// equivalent slot and reject conditions. Uses bti_pkg.
module bti_scan #(
    parameter int BEAM_MAX = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic [BEAM_MAX-1:0] gt_vec,
    input  logic [BEAM_MAX-1:0] match_vec,
    input  logic [CNT_W-1:0]    count,
    input  logic [CNT_W-1:0]    w_eff,
    output logic [CNT_W-1:0]    pos,
    output logic [IDX_W-1:0]    k_idx,
    output bti_pkg::scan_flags_t flags
);

    logic [BEAM_MAX-1:0] valid_vec;
    logic [BEAM_MAX-1:0] hit_vec;
    logic [CNT_W-1:0]    count_m1;
    logic                tail_gt;

    always_comb
    begin
        for (int i = 0; i < BEAM_MAX; i++)
        begin
            valid_vec[i] = 32'(i) < 32'(count);
        end
    end

    assign hit_vec  = match_vec & valid_vec;
    assign count_m1 = count - CNT_W'(1);
    assign tail_gt  = gt_vec[IDX_W'(count_m1)];

    // entries are sorted, so the first slot the candidate beats is its place
    always_comb
    begin
        pos   = count;
        k_idx = '0;
        for (int i = BEAM_MAX - 1; i >= 0; i--)
        begin
            if (valid_vec[i] && gt_vec[i])
            begin
                pos = CNT_W'(i);
            end
            if (hit_vec[i])
            begin
                k_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        flags.found       = |hit_vec;
        flags.full_reject = (count != '0) && (count >= w_eff) && !tail_gt;
        flags.dominated   = (|hit_vec) && !(|(hit_vec & gt_vec));
    end

endmodule

[src/beam_topk_insert_recombine_unit.sv]
// Beam top-k insert/recombine unit: top level with handshake, sequencer and
// the chain of slot cells. Uses bti_pkg, bti_cell and bti_scan.
//
// Keeps one beam of up to BEAM_MAX hypotheses sorted by descending signed
// Q16.16 score, each slot a cell that holds (tag_prev, tag_cur, score,
// back pointer). Commands: clear, insert (with recombination on an equal tag
// pair), read one slot. Every command gives exactly one result beat. An
// item passes through the accept state, an eval state in which every cell
// compares its entry with the candidate in parallel and latches the flags,
// and a commit state in which the flags are reduced to a landing slot and
// each cell loads the candidate, its upper neighbor or keeps its entry. No
// new beat is taken before the last one commits. The result sits in an
// output register; the next beat may be accepted while it waits, and the
// commit only stalls if the previous result is still not taken. beam_width
// is to be written through cfg_wen/cfg_wdata by the user only while the
// unit is idle, which is not enforced. 0 behaves as 1 and values above
// BEAM_MAX as BEAM_MAX. Lowering it shrinks the beam on the next accepted
// insert. Slots at or beyond the entry count read as empty with zero data.
module beam_topk_insert_recombine_unit #(
    parameter int BEAM_MAX = bti_pkg::BEAM_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cand_valid,
    output logic               cand_stall,
    input  bti_pkg::in_beat_t  cand_beat,
    output logic               res_valid,
    input  logic               res_stall,
    output bti_pkg::out_beat_t res_beat,
    input  logic               cfg_wen,
    input  logic [4:0]         cfg_wdata
);

    localparam int IDX_W = (BEAM_MAX > 1) ? $clog2(BEAM_MAX) : 1;
    localparam int CNT_W = $clog2(BEAM_MAX + 1);

    // sequencer
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    bti_pkg::in_beat_t   cand_reg;
    logic [4:0]          beam_width_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                res_valid_reg;
    bti_pkg::out_beat_t  res_beat_reg;
    bti_pkg::out_beat_t  res_beat_next;

    logic                in_take;
    logic                out_free;
    logic                do_commit;
    logic                insert_ok;
    logic [CNT_W-1:0]    w_eff;
    logic [CNT_W:0]      n_tmp;
    logic [CNT_W-1:0]    n_new;

    bti_pkg::hyp_t       cand_hyp;
    bti_pkg::hyp_t       entries [BEAM_MAX];
    bti_pkg::hyp_t       rd_entry;
    logic [BEAM_MAX-1:0] gt_vec;
    logic [BEAM_MAX-1:0] match_vec;
    bti_pkg::cell_ctrl_t cell_ctrl;
    logic [CNT_W-1:0]    pos;
    logic [IDX_W-1:0]    k_idx;
    bti_pkg::scan_flags_t scan_flags;
    logic                rd_hit;

    assign in_take   = cand_valid && !cand_stall;
    assign cand_stall = (state_reg != S_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign do_commit = (state_reg == S_COMMIT) && out_free;

    // effective width, clamped to [1, BEAM_MAX]
    always_comb
    begin
        if (beam_width_reg == 5'd0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (32'(beam_width_reg) > BEAM_MAX)
        begin
            w_eff = CNT_W'(BEAM_MAX);
        end
        else
        begin
            w_eff = CNT_W'(beam_width_reg);
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:   state_next = in_take ? S_EVAL : S_IDLE;
            S_EVAL:   state_next = S_COMMIT;
            S_COMMIT: state_next = out_free ? S_IDLE : S_COMMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            beam_width_reg <= bti_pkg::BEAM_WIDTH_RST;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                beam_width_reg <= cfg_wdata;
            end
            if (do_commit)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cand_reg <= cand_beat;
        end
        if (do_commit)
        begin
            res_beat_reg <= res_beat_next;
        end
    end

    assign cand_hyp.tag_prev = cand_reg.tag_prev;
    assign cand_hyp.tag_cur  = cand_reg.tag_cur;
    assign cand_hyp.score    = cand_reg.cand_score;
    assign cand_hyp.back     = cand_reg.back_index;

    // slot cells; cell i shifts in cell i-1 when the candidate lands above it
    for (genvar g = 0; g < BEAM_MAX; g++)
    begin : g_cell
        bti_pkg::hyp_t prev_hyp;
        if (g == 0)
        begin : g_head
            assign prev_hyp = cand_hyp;
        end
        else
        begin : g_body
            assign prev_hyp = entries[g-1];
        end
        bti_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk   (clk),
            .ctrl  (cell_ctrl),
            .pos   (IDX_W'(pos)),
            .k_idx (k_idx),
            .cand  (cand_hyp),
            .prev  (prev_hyp),
            .entry (entries[g]),
            .gt    (gt_vec[g]),
            .match (match_vec[g])
        );
    end

    bti_scan #(
        .BEAM_MAX (BEAM_MAX),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_scan (
        .gt_vec    (gt_vec),
        .match_vec (match_vec),
        .count     (count_reg),
        .w_eff     (w_eff),
        .pos       (pos),
        .k_idx     (k_idx),
        .flags     (scan_flags)
    );

    // read port: only slots below the entry count are ever shown
    assign rd_hit   = (32'(cand_reg.read_slot) < 32'(count_reg)) &&
                      (32'(cand_reg.read_slot) < BEAM_MAX);
    assign rd_entry = entries[IDX_W'(cand_reg.read_slot)];

    // accepted insert: recombined entry drops out, count grows only for a
    // new key, then the beam is cut to the width
    assign insert_ok = (cand_reg.command == bti_pkg::CMD_INSERT) &&
                       !scan_flags.full_reject && !scan_flags.dominated;
    assign n_tmp     = scan_flags.found ? {1'b0, count_reg} : {1'b0, count_reg} + (CNT_W+1)'(1);
    assign n_new     = (n_tmp > {1'b0, w_eff}) ? w_eff : n_tmp[CNT_W-1:0];

    always_comb
    begin
        cell_ctrl.eval   = (state_reg == S_EVAL);
        cell_ctrl.commit = do_commit && insert_ok;
        cell_ctrl.found  = scan_flags.found;

        res_beat_next = '0;
        count_next    = count_reg;
        case (cand_reg.command)
            bti_pkg::CMD_CLEAR:
            begin
                count_next           = '0;
                res_beat_next.status = bti_pkg::STAT_CLEARED;
            end
            bti_pkg::CMD_INSERT:
            begin
                if (scan_flags.full_reject)
                begin
                    res_beat_next.status = bti_pkg::STAT_REJ_FULL;
                end
                else if (scan_flags.dominated)
                begin
                    res_beat_next.status = bti_pkg::STAT_REJ_DOM;
                end
                else
                begin
                    count_next = n_new;
                    if (pos >= n_new)
                    begin
                        res_beat_next.status = bti_pkg::STAT_REJ_FULL;
                    end
                    else
                    begin
                        res_beat_next.status   = scan_flags.found ? bti_pkg::STAT_REPLACED
                                                                  : bti_pkg::STAT_INSERTED;
                        res_beat_next.position = 4'(pos);
                    end
                end
            end
            default:
            begin
                // read, and the unused code three
                res_beat_next.position = cand_reg.read_slot;
                if (rd_hit)
                begin
                    res_beat_next.status         = bti_pkg::STAT_READ_OK;
                    res_beat_next.out_tag_prev   = rd_entry.tag_prev;
                    res_beat_next.out_tag_cur    = rd_entry.tag_cur;
                    res_beat_next.out_score      = rd_entry.score;
                    res_beat_next.out_back_index = rd_entry.back;
                end
                else
                begin
                    res_beat_next.status = bti_pkg::STAT_READ_EMPTY;
                end
            end
        endcase
        res_beat_next.entry_count = 5'(count_next);
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

endmodule

[bench/beam_topk_checker.sv]
// Scoreboard for the beam top-k insert/recombine unit: keeps a shadow beam,
// predicts each result beat from the accepted command beats and compares.
// Depends on bti_pkg for the beat types and the command and status codes.
module beam_topk_checker #(
    parameter int BEAM_MAX = bti_pkg::BEAM_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cand_valid,
    input  logic               cand_stall,
    input  bti_pkg::in_beat_t  cand_beat,
    input  logic               res_valid,
    input  logic               res_stall,
    input  bti_pkg::out_beat_t res_beat,
    input  logic               cfg_wen,
    input  logic [4:0]         cfg_wdata,
    output int                 mismatches,
    output int                 outstanding
);

    // one spare slot: an insert into a full beam lands before the cut
    bti_pkg::hyp_t      shadow_beam [BEAM_MAX + 1];
    int                 shadow_count;
    logic [4:0]         shadow_width;
    bti_pkg::out_beat_t awaited_results [$];
    bti_pkg::out_beat_t want;

    function automatic bit beats(logic [31:0] a, logic [31:0] b);
        return $signed(a) > $signed(b);
    endfunction

    // Applies one command to the shadow beam and returns the result beat.
    function automatic bti_pkg::out_beat_t beam_step(bti_pkg::in_beat_t b);
        bti_pkg::out_beat_t r;
        bti_pkg::hyp_t      cand;
        int                 n;
        int                 w;
        int                 k;
        int                 pos;
        bit                 found;
        r = '0;
        n = shadow_count;
        k = 0;
        pos = 0;
        found = 1'b0;
        case (b.command)
            bti_pkg::CMD_CLEAR:
            begin
                n = 0;
                r.status = bti_pkg::STAT_CLEARED;
            end
            bti_pkg::CMD_INSERT:
            begin
                w = (shadow_width == 5'd0) ? 1 :
                    (int'(shadow_width) > BEAM_MAX) ? BEAM_MAX : int'(shadow_width);
                cand.tag_prev = b.tag_prev;
                cand.tag_cur  = b.tag_cur;
                cand.score    = b.cand_score;
                cand.back     = b.back_index;
                if (n == 0)
                begin
                    shadow_beam[0] = cand;
                    n = 1;
                    r.status = bti_pkg::STAT_INSERTED;
                end
                else if (n >= w && !beats(cand.score, shadow_beam[n - 1].score))
                begin
                    r.status = bti_pkg::STAT_REJ_FULL;
                end
                else
                begin
                    // last matching key wins, as the scan runs from the tail
                    for (int i = n - 1; i >= 0; i--)
                    begin
                        if (!found && shadow_beam[i].tag_prev == cand.tag_prev &&
                            shadow_beam[i].tag_cur == cand.tag_cur)
                        begin
                            found = 1'b1;
                            k = i;
                        end
                    end
                    if (found && !beats(cand.score, shadow_beam[k].score))
                    begin
                        r.status = bti_pkg::STAT_REJ_DOM;
                    end
                    else
                    begin
                        if (found)
                        begin
                            for (int i = k; i + 1 < n; i++)
                                shadow_beam[i] = shadow_beam[i + 1];
                            n--;
                            r.status = bti_pkg::STAT_REPLACED;
                        end
                        else
                        begin
                            r.status = bti_pkg::STAT_INSERTED;
                        end
                        // ties stay behind existing entries
                        pos = n;
                        while (pos > 0 && beats(cand.score, shadow_beam[pos - 1].score))
                            pos--;
                        for (int i = n; i > pos; i--)
                            shadow_beam[i] = shadow_beam[i - 1];
                        shadow_beam[pos] = cand;
                        n++;
                        if (n > w)
                            n = w;
                        if (pos >= n)
                        begin
                            r.status = bti_pkg::STAT_REJ_FULL;
                            pos = 0;
                        end
                    end
                end
                r.position = pos[3:0];
            end
            default:
            begin
                // read, and the spare command code behaves the same
                r.position = b.read_slot;
                if (int'(b.read_slot) < n)
                begin
                    r.status         = bti_pkg::STAT_READ_OK;
                    r.out_tag_prev   = shadow_beam[b.read_slot].tag_prev;
                    r.out_tag_cur    = shadow_beam[b.read_slot].tag_cur;
                    r.out_score      = shadow_beam[b.read_slot].score;
                    r.out_back_index = shadow_beam[b.read_slot].back;
                end
                else
                begin
                    r.status = bti_pkg::STAT_READ_EMPTY;
                end
            end
        endcase
        shadow_count = n;
        r.entry_count = n[4:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] got);
        if (expected !== got)
        begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, expected, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            shadow_width = bti_pkg::BEAM_WIDTH_RST;
            awaited_results.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
                shadow_width = cfg_wdata;
            // a result can never come out at the edge its command goes in
            if (res_valid && !res_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $error("result beat with nothing expected: %0h", res_beat);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(res_beat.status));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(res_beat.entry_count));
                    check_field("position", 32'(want.position), 32'(res_beat.position));
                    check_field("out_tag_prev", 32'(want.out_tag_prev),
                                32'(res_beat.out_tag_prev));
                    check_field("out_tag_cur", 32'(want.out_tag_cur),
                                32'(res_beat.out_tag_cur));
                    check_field("out_score", want.out_score, res_beat.out_score);
                    check_field("out_back_index", 32'(want.out_back_index),
                                32'(res_beat.out_back_index));
                end
            end
            if (cand_valid && !cand_stall)
                awaited_results.insert(awaited_results.size(), beam_step(cand_beat));
            outstanding <= awaited_results.size();
        end
    end

endmodule

[bench/beam_topk_insert_recombine_unit_tb.sv]
// Top of the bench for the beam top-k insert/recombine unit: clock, reset,
// command stimulus, result backpressure and the verdict.
// Depends on bti_pkg, beam_topk_insert_recombine_unit and beam_topk_checker.
module beam_topk_insert_recombine_unit_tb;

    // the command field has one code beyond read; the unit treats it as read
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // receiver backpressure styles, rotated at random
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_CHOKE,
        DRAIN_PERIODIC
    } drain_mode_t;

    logic               clk;
    logic               rst_n;
    logic               cand_valid;
    logic               cand_stall;
    bti_pkg::in_beat_t  cand_beat;
    logic               res_valid;
    logic               res_stall = 1'b0;
    bti_pkg::out_beat_t res_beat;
    logic               cfg_wen;
    logic [4:0]         cfg_wdata;
    int                 mismatches;
    int                 outstanding;

    drain_mode_t drain_mode = DRAIN_FREE;
    int          drain_left = 0;

    // width settings for the random phases: the beam fills at full width first,
    // then lowering to four forces the over-width cut; zero and values above
    // the maximum check the clamping
    logic [4:0] width_plan [10] = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31,
                                    5'd17, 5'd2, 5'd8, 5'd3, 5'd16};

    beam_topk_insert_recombine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand_beat  (cand_beat),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_beat   (res_beat),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata)
    );

    beam_topk_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cand_valid  (cand_valid),
        .cand_stall  (cand_stall),
        .cand_beat   (cand_beat),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_beat    (res_beat),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: every so often pick a new stall style and hold it for a
    // random stretch, so stalls land on every phase of an item's sequence.
    always @(posedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_mode <= drain_mode_t'($urandom_range(0, 3));
            drain_left <= int'($urandom_range(5, 40));
        end
        else
        begin
            drain_left <= drain_left - 1;
        end
        case (drain_mode)
            DRAIN_FREE:     res_stall <= 1'b0;
            DRAIN_COIN:     res_stall <= 1'($urandom_range(0, 1));
            DRAIN_CHOKE:    res_stall <= ($urandom_range(0, 9) < 8);
            DRAIN_PERIODIC: res_stall <= (drain_left[2:0] != 3'd0);
            default:        res_stall <= 1'b0;
        endcase
    end

    function automatic bti_pkg::in_beat_t mk(logic [1:0] cmd, logic [7:0] tp,
                                             logic [7:0] tc, logic [31:0] score,
                                             logic [3:0] bk, logic [3:0] slot);
        bti_pkg::in_beat_t b;
        b.command    = cmd;
        b.tag_prev   = tp;
        b.tag_cur    = tc;
        b.cand_score = score;
        b.back_index = bk;
        b.read_slot  = slot;
        return b;
    endfunction

    // Mostly small values so ties are common, plus full-range and extremes.
    function automatic logic [31:0] rand_score();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 16)) - 8);
            1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    // Inserts dominate; keys come from a tiny pool most of the time so that
    // recombination, domination and replacement happen often.
    function automatic bti_pkg::in_beat_t make_item();
        bti_pkg::in_beat_t b;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        b.command = (pick < 3)  ? bti_pkg::CMD_CLEAR :
                    (pick < 75) ? bti_pkg::CMD_INSERT :
                    (pick < 95) ? bti_pkg::CMD_READ : CMD_SPARE;
        if ($urandom_range(0, 4) != 0)
        begin
            b.tag_prev = 8'($urandom_range(0, 3));
            b.tag_cur  = 8'($urandom_range(0, 3));
        end
        else
        begin
            b.tag_prev = 8'($urandom_range(0, 255));
            b.tag_cur  = 8'($urandom_range(0, 255));
        end
        b.cand_score = rand_score();
        b.back_index = 4'($urandom_range(0, 15));
        b.read_slot  = 4'($urandom_range(0, 15));
        return b;
    endfunction

    // Present one beat and hold it until it is taken. Valid is left high so
    // a following beat goes out back to back.
    task automatic send_beat(bti_pkg::in_beat_t b);
        cand_beat  <= b;
        cand_valid <= 1'b1;
        @(posedge clk);
        while (cand_stall)
            @(posedge clk);
    endtask

    // Lower valid and wait until every predicted result has been taken.
    // The outstanding count is registered, so valid is brought down before
    // the count is trusted.
    task automatic wait_drained();
        if (cand_valid)
        begin
            cand_valid <= 1'b0;
            @(posedge clk);
        end
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_width(logic [4:0] w);
        wait_drained();
        cfg_wdata <= w;
        cfg_wen   <= 1'b1;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Random beats in bursts of random length with random gaps; a gap of
    // zero joins two bursts into one long back-to-back stretch.
    task automatic send_random(int count);
        int burst = 0;
        int gap;
        for (int j = 0; j < count; j++)
        begin
            if (burst == 0)
            begin
                burst = int'($urandom_range(1, 40));
                gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
                if (gap > 0 && cand_valid)
                begin
                    cand_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_beat(make_item());
            burst--;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cand_valid = 1'b0;
        cand_beat  = '0;
        cfg_wen    = 1'b0;
        cfg_wdata  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset width of sixteen.
        // empty beam
        send_beat(mk(bti_pkg::CMD_READ, 8'd0, 8'd0, 32'd0, 4'd0, 4'd0));
        // first entry
        send_beat(mk(bti_pkg::CMD_INSERT, 8'd0, 8'd0, 32'd0, 4'd0, 4'd0));
        // top score
        send_beat(mk(bti_pkg::CMD_INSERT, 8'd255, 8'd255, 32'h7FFF_FFFF, 4'd15, 4'd15));
        // bottom score
        send_beat(mk(bti_pkg::CMD_INSERT, 8'd1, 8'd2, 32'h8000_0000, 4'd5, 4'd0));
        // same key, tie
        send_beat(mk(bti_pkg::CMD_INSERT, 8'd1, 8'd2, 32'h8000_0000, 4'd6, 4'd0));
        // same key, better
        send_beat(mk(bti_pkg::CMD_INSERT, 8'd1, 8'd2, 32'hFFFB_0000, 4'd7, 4'd0));
        // tie goes behind
        send_beat(mk(bti_pkg::CMD_INSERT, 8'd3, 8'd4, 32'd0, 4'd9, 4'd0));
        // moves up
        send_beat(mk(bti_pkg::CMD_INSERT, 8'd0, 8'd0, 32'h0000_0001, 4'd10, 4'd0));
        send_beat(mk(bti_pkg::CMD_READ, 8'd0, 8'd0, 32'd0, 4'd0, 4'd0));
        send_beat(mk(bti_pkg::CMD_READ, 8'd0, 8'd0, 32'd0, 4'd0, 4'd1));
        send_beat(mk(bti_pkg::CMD_READ, 8'd0, 8'd0, 32'd0, 4'd0, 4'd2));
        // spare code reads
        send_beat(mk(CMD_SPARE, 8'd0, 8'd0, 32'd0, 4'd0, 4'd3));
        // past the end
        send_beat(mk(bti_pkg::CMD_READ, 8'd0, 8'd0, 32'd0, 4'd0, 4'd4));
        // last slot
        send_beat(mk(bti_pkg::CMD_READ, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 4'd15));
        send_beat(mk(bti_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF, 4'hF));
        // cleared
        send_beat(mk(bti_pkg::CMD_READ, 8'd0, 8'd0, 32'd0, 4'd0, 4'd0));

        // Random phases, each behind a full drain and a width change. The
        // beam is not cleared in between, so a lowered width cuts it down.
        foreach (width_plan[p])
        begin
            set_width(width_plan[p]);
            send_random(100);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS beam_topk_insert_recombine_unit");
        else
            $display("FAIL beam_topk_insert_recombine_unit");
        $finish;
    end

    // Timeout; a correct run ends well before it even with every result held
    // by the longest stall stretch.
    initial
    begin
        #3000000;
        $display("FAIL beam_topk_insert_recombine_unit");
        $finish;
    end

endmodule
